// ===== design/ps2kc_pkg.sv =====
`default_nettype none

package ps2kc_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned ReqTypeW = 3;
  localparam int unsigned PortW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned DeltaW   = 11;
  localparam int unsigned ButtonW  = 3;

  // Request type codes.
  localparam logic [ReqTypeW-1:0] ReqBusRead  = 3'd0;
  localparam logic [ReqTypeW-1:0] ReqBusWrite = 3'd1;
  localparam logic [ReqTypeW-1:0] ReqKey      = 3'd2;
  localparam logic [ReqTypeW-1:0] ReqMouse    = 3'd3;
  localparam logic [ReqTypeW-1:0] ReqRefresh  = 3'd4;

  // I/O ports decoded by the controller.
  localparam logic [PortW-1:0] PortData = 16'h0060;
  localparam logic [PortW-1:0] PortCmd  = 16'h0064;

  // Controller commands written to the command port.
  localparam logic [ByteW-1:0] CmdReadCb = 8'h20;
  localparam logic [ByteW-1:0] CmdWrCb   = 8'h60;
  localparam logic [ByteW-1:0] CmdKbdOff = 8'hAD;
  localparam logic [ByteW-1:0] CmdKbdOn  = 8'hAE;
  localparam logic [ByteW-1:0] CmdAux    = 8'hD4;

  // Mouse commands passed through the data port, and the mouse answers.
  localparam logic [ByteW-1:0] MsEnable  = 8'hF4;
  localparam logic [ByteW-1:0] MsDisable = 8'hF5;
  localparam logic [ByteW-1:0] MsDefault = 8'hF6;
  localparam logic [ByteW-1:0] MsReset   = 8'hFF;
  localparam logic [ByteW-1:0] MsStream  = 8'hEA;
  localparam logic [ByteW-1:0] MsSetSmp  = 8'hF0;
  localparam logic [ByteW-1:0] MsReadDat = 8'hEB;
  localparam logic [ByteW-1:0] AckByte   = 8'hFA;
  localparam logic [ByteW-1:0] NackByte  = 8'hFE;

  // Keyboard disable bit of the command byte.
  localparam logic [ByteW-1:0] CbKbdDis = 8'h10;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       load;       // capture the request beat
    logic       exec;       // apply register side effects of the request
    logic       push;       // push one output byte
    logic [1:0] push_idx;   // which byte of the request is pushed
    logic       ram_rd;     // read the queue head
    logic       cap_status; // build the status byte from the head entry
    logic       cap_pop;    // pop the head entry into the read data
    logic       cap_raise;  // raise the interrupt for the head entry
    logic       out_load;   // move the finished result to the output register
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic [1:0] n_push;     // bytes this request pushes
    logic       rd_status;  // bus read of the status port
    logic       rd_data;    // bus read of the data port
    logic       refresh;    // refresh interrupt request
    logic       cnt_zero;   // queue is empty
    logic       cnt_one;    // queue holds exactly one byte
  } status_t;

endpackage

`default_nettype wire

// ===== design/ps2kc_if.sv =====
`default_nettype none

interface ps2kc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ps2kc_pkg::ReqTypeW-1:0]       req_type;
  logic [ps2kc_pkg::PortW-1:0]          port;
  logic [ps2kc_pkg::ByteW-1:0]          data_byte;
  logic signed [ps2kc_pkg::DeltaW-1:0]  mouse_dx;
  logic signed [ps2kc_pkg::DeltaW-1:0]  mouse_dy;
  logic [ps2kc_pkg::ButtonW-1:0]        mouse_buttons;

  modport source (
    output valid, req_type, port, data_byte, mouse_dx, mouse_dy, mouse_buttons,
    input  ready
  );
  modport sink (
    input  valid, req_type, port, data_byte, mouse_dx, mouse_dy, mouse_buttons,
    output ready
  );
endinterface

interface ps2kc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ps2kc_pkg::ByteW-1:0]   read_data;
  logic                          handled;
  logic                          kbd_irq;
  logic                          aux_irq;
  logic                          overflow;

  modport source (
    output valid, read_data, handled, kbd_irq, aux_irq, overflow,
    input  ready
  );
  modport sink (
    input  valid, read_data, handled, kbd_irq, aux_irq, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/ps2kc_ram.sv =====
`default_nettype none

module ps2kc_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2kc_ctrl.sv =====
`default_nettype none

module ps2kc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire ps2kc_pkg::status_t status_i,
  output ps2kc_pkg::cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECODE     = 3'd1;
  localparam logic [2:0] S_PUSH       = 3'd2;
  localparam logic [2:0] S_RD_REQ     = 3'd3;
  localparam logic [2:0] S_RD_DATA    = 3'd4;
  localparam logic [2:0] S_RAISE_REQ  = 3'd5;
  localparam logic [2:0] S_RAISE_DATA = 3'd6;
  localparam logic [2:0] S_FINISH     = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] npush_q, npush_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    npush_d = npush_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.exec = 1'b1;
        idx_d      = 2'd0;
        npush_d    = status_i.n_push;
        if (status_i.n_push != 2'd0) begin
          state_d = S_PUSH;
        end else if ((status_i.rd_status || status_i.rd_data) && !status_i.cnt_zero) begin
          state_d = S_RD_REQ;
        end else if (status_i.refresh && !status_i.cnt_zero) begin
          state_d = S_RAISE_REQ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_PUSH: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_idx = idx_q;
        if (idx_q == npush_q - 2'd1) begin
          state_d = S_FINISH;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      S_RD_REQ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (status_i.rd_status) begin
          cmd_o.cap_status = 1'b1;
          state_d          = S_FINISH;
        end else begin
          cmd_o.cap_pop = 1'b1;
          state_d       = status_i.cnt_one ? S_FINISH : S_RAISE_REQ;
        end
      end
      S_RAISE_REQ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_RAISE_DATA;
      end
      S_RAISE_DATA: begin
        cmd_o.cap_raise = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      npush_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      npush_q     <= npush_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2kc_datapath.sv =====
`default_nettype none

module ps2kc_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire ps2kc_pkg::cmd_t                      cmd_i,
  output ps2kc_pkg::status_t                        status_o,
  input  wire logic [ps2kc_pkg::ReqTypeW-1:0]       req_type_i,
  input  wire logic [ps2kc_pkg::PortW-1:0]          port_i,
  input  wire logic [ps2kc_pkg::ByteW-1:0]          data_byte_i,
  input  wire logic signed [ps2kc_pkg::DeltaW-1:0]  mouse_dx_i,
  input  wire logic signed [ps2kc_pkg::DeltaW-1:0]  mouse_dy_i,
  input  wire logic [ps2kc_pkg::ButtonW-1:0]        mouse_buttons_i,
  output logic [ps2kc_pkg::ByteW-1:0]               read_data_o,
  output logic                                      handled_o,
  output logic                                      kbd_irq_o,
  output logic                                      aux_irq_o,
  output logic                                      overflow_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0]  PendNone  = 2'd0;
  localparam logic [1:0]  PendCb    = 2'd1;
  localparam logic [1:0]  PendAux   = 2'd2;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Captured request.
  logic [2:0]         req_q, req_d;
  logic [15:0]        port_q, port_d;
  logic [7:0]         db_q, db_d;
  logic signed [10:0] dx_q, dx_d;
  logic signed [10:0] dy_q, dy_d;
  logic [2:0]         btn_q, btn_d;

  // Controller state.
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      ctrl_q, ctrl_d;
  logic            kbd_en_q, kbd_en_d;
  logic            rep_q, rep_d;
  logic [1:0]      pend_q, pend_d;

  // Result being built, and the output register.
  logic [7:0] rd_q, rd_d;
  logic       hit_q, hit_d;
  logic       irqk_q, irqk_d;
  logic       irqm_q, irqm_d;
  logic       drop_q, drop_d;
  logic [7:0] out_rd_q, out_rd_d;
  logic       out_hit_q, out_hit_d;
  logic       out_irqk_q, out_irqk_d;
  logic       out_irqm_q, out_irqm_d;
  logic       out_drop_q, out_drop_d;

  logic            ram_we;
  logic [8:0]      ram_rdata;
  logic [8:0]      push_byte;
  logic            is_data, is_cmd, hit, ms_ack, dx_neg, dy_neg;
  logic [7:0]      dx_byte, dy_byte;
  logic [1:0]      n_push;

  ps2kc_ram #(
    .WIDTH (9),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (push_byte),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign is_data = (port_q == ps2kc_pkg::PortData);
  assign is_cmd  = (port_q == ps2kc_pkg::PortCmd);
  assign hit     = ((req_q == ps2kc_pkg::ReqBusRead) || (req_q == ps2kc_pkg::ReqBusWrite))
                   && (is_data || is_cmd);
  assign ms_ack  = (db_q == ps2kc_pkg::MsEnable) || (db_q == ps2kc_pkg::MsDisable) ||
                   (db_q == ps2kc_pkg::MsDefault) || (db_q == ps2kc_pkg::MsReset) ||
                   (db_q == ps2kc_pkg::MsStream) || (db_q == ps2kc_pkg::MsSetSmp) ||
                   (db_q == ps2kc_pkg::MsReadDat);

  // Clamping keeps the sign, so the sign bits come straight from the input.
  assign dx_neg  = dx_q[10];
  assign dy_neg  = dy_q[10];
  assign dx_byte = (dx_q > 11'sd255) ? 8'hFF : ((dx_q < -11'sd255) ? 8'h01 : dx_q[7:0]);
  assign dy_byte = (dy_q > 11'sd255) ? 8'hFF : ((dy_q < -11'sd255) ? 8'h01 : dy_q[7:0]);

  always_comb begin
    n_push = 2'd0;
    if (req_q == ps2kc_pkg::ReqBusWrite && is_cmd && db_q == ps2kc_pkg::CmdReadCb) begin
      n_push = 2'd1;
    end else if (req_q == ps2kc_pkg::ReqBusWrite && is_data && pend_q == PendAux) begin
      n_push = 2'd1;
    end else if (req_q == ps2kc_pkg::ReqKey && kbd_en_q) begin
      n_push = 2'd1;
    end else if (req_q == ps2kc_pkg::ReqMouse && rep_q) begin
      n_push = 2'd3;
    end
  end

  always_comb begin
    if (req_q == ps2kc_pkg::ReqKey) begin
      push_byte = {1'b0, db_q};
    end else if (req_q == ps2kc_pkg::ReqMouse) begin
      unique case (cmd_i.push_idx)
        2'd0:    push_byte = {1'b1, 2'b00, dy_neg, dx_neg, 1'b1, btn_q};
        2'd1:    push_byte = {1'b1, dx_byte};
        default: push_byte = {1'b1, dy_byte};
      endcase
    end else if (is_cmd) begin
      push_byte = {1'b0, ctrl_q};
    end else begin
      push_byte = {1'b1, ms_ack ? ps2kc_pkg::AckByte : ps2kc_pkg::NackByte};
    end
  end

  always_comb begin
    status_o.n_push    = n_push;
    status_o.rd_status = (req_q == ps2kc_pkg::ReqBusRead) && is_cmd;
    status_o.rd_data   = (req_q == ps2kc_pkg::ReqBusRead) && is_data;
    status_o.refresh   = (req_q == ps2kc_pkg::ReqRefresh);
    status_o.cnt_zero  = (count_q == '0);
    status_o.cnt_one   = (count_q == CntW'(1));
  end

  always_comb begin
    req_d = req_q;  port_d = port_q;  db_d = db_q;
    dx_d = dx_q;    dy_d = dy_q;      btn_d = btn_q;
    head_d = head_q;  tail_d = tail_q;  count_d = count_q;
    ctrl_d = ctrl_q;  kbd_en_d = kbd_en_q;  rep_d = rep_q;  pend_d = pend_q;
    rd_d = rd_q;  hit_d = hit_q;  irqk_d = irqk_q;  irqm_d = irqm_q;  drop_d = drop_q;
    out_rd_d = out_rd_q;  out_hit_d = out_hit_q;  out_irqk_d = out_irqk_q;
    out_irqm_d = out_irqm_q;  out_drop_d = out_drop_q;
    ram_we = 1'b0;

    if (cmd_i.load) begin
      req_d  = req_type_i;
      port_d = port_i;
      db_d   = data_byte_i;
      dx_d   = mouse_dx_i;
      dy_d   = mouse_dy_i;
      btn_d  = mouse_buttons_i;
      rd_d   = 8'h00;
      hit_d  = 1'b0;
      irqk_d = 1'b0;
      irqm_d = 1'b0;
      drop_d = 1'b0;
    end

    if (cmd_i.exec) begin
      hit_d = hit;
      if (req_q == ps2kc_pkg::ReqBusWrite && is_cmd) begin
        unique case (db_q)
          ps2kc_pkg::CmdWrCb:   pend_d = PendCb;
          ps2kc_pkg::CmdKbdOff: begin
            kbd_en_d = 1'b0;
            ctrl_d   = ctrl_q | ps2kc_pkg::CbKbdDis;
          end
          ps2kc_pkg::CmdKbdOn:  begin
            kbd_en_d = 1'b1;
            ctrl_d   = ctrl_q & ~ps2kc_pkg::CbKbdDis;
          end
          ps2kc_pkg::CmdAux:    pend_d = PendAux;
          default:   ;
        endcase
      end else if (req_q == ps2kc_pkg::ReqBusWrite && is_data) begin
        if (pend_q == PendCb) begin
          ctrl_d   = db_q;
          kbd_en_d = !db_q[4];
          pend_d   = PendNone;
        end else if (pend_q == PendAux) begin
          pend_d = PendNone;
          if (db_q == ps2kc_pkg::MsEnable) begin
            rep_d = 1'b1;
          end else if (db_q == ps2kc_pkg::MsDisable || db_q == ps2kc_pkg::MsDefault ||
                       db_q == ps2kc_pkg::MsReset) begin
            rep_d = 1'b0;
          end
        end
      end
    end

    if (cmd_i.push) begin
      if (count_q == CntW'(QUEUE_DEPTH)) begin
        drop_d = 1'b1;
      end else begin
        ram_we  = 1'b1;
        tail_d  = ptr_inc(tail_q);
        count_d = count_q + 1'b1;
        // A byte pushed into an empty queue becomes the head.
        if (count_q == '0) begin
          irqm_d = irqm_q | (push_byte[8] & ctrl_q[1]);
          irqk_d = irqk_q | (!push_byte[8] & ctrl_q[0]);
        end
      end
    end

    if (cmd_i.cap_status) begin
      rd_d = {2'b00, ram_rdata[8], 4'b0000, 1'b1};
    end

    if (cmd_i.cap_pop) begin
      rd_d    = ram_rdata[7:0];
      head_d  = ptr_inc(head_q);
      count_d = count_q - 1'b1;
    end

    if (cmd_i.cap_raise) begin
      irqm_d = irqm_q | (ram_rdata[8] & ctrl_q[1]);
      irqk_d = irqk_q | (!ram_rdata[8] & ctrl_q[0]);
    end

    if (cmd_i.out_load) begin
      out_rd_d   = rd_q;
      out_hit_d  = hit_q;
      out_irqk_d = irqk_q;
      out_irqm_d = irqm_q;
      out_drop_d = drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      ctrl_q   <= 8'h00;
      kbd_en_q <= 1'b1;
      rep_q    <= 1'b0;
      pend_q   <= PendNone;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      kbd_en_q <= kbd_en_d;
      rep_q    <= rep_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    port_q     <= port_d;
    db_q       <= db_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    btn_q      <= btn_d;
    rd_q       <= rd_d;
    hit_q      <= hit_d;
    irqk_q     <= irqk_d;
    irqm_q     <= irqm_d;
    drop_q     <= drop_d;
    out_rd_q   <= out_rd_d;
    out_hit_q  <= out_hit_d;
    out_irqk_q <= out_irqk_d;
    out_irqm_q <= out_irqm_d;
    out_drop_q <= out_drop_d;
  end

  assign read_data_o = out_rd_q;
  assign handled_o   = out_hit_q;
  assign kbd_irq_o   = out_irqk_q;
  assign aux_irq_o   = out_irqm_q;
  assign overflow_o  = out_drop_q;

endmodule

`default_nettype wire

// ===== design/ps2_keyboard_controller.sv =====
// Channel   Dir  Payload                                                Beat
// req_i     in   req_type, port, data_byte, mouse_dx/dy, mouse_buttons  one request
// rsp_o     out  read_data, handled, kbd_irq, aux_irq, overflow         one result per request
//
// Requests are taken one at a time: accept, decode, then a push state for each pushed byte,
// a request and a data state per queue read, and a finish state that hands the result to
// the output register once it is free. A data read that leaves bytes in the queue also
// reads the new head to raise its interrupt. The queue memory read is registered.
// Reset empties the queue, clears the command byte and the pending write, turns
// mouse reporting off and enables the keyboard; there is no clearing pass.
// A result waiting in the output register does not block the next request; only a
// second finished result waits until the first beat has been taken.
`default_nettype none

module ps2_keyboard_controller #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ps2kc_req_if.sink  req_i,
  ps2kc_rsp_if.source rsp_o
);

  ps2kc_pkg::cmd_t    cmd;
  ps2kc_pkg::status_t status;

  // The sequencer owns all handshake state; the datapath owns the queue and
  // the controller registers and only follows commands.
  ps2kc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ps2kc_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_i.req_type),
    .port_i          (req_i.port),
    .data_byte_i     (req_i.data_byte),
    .mouse_dx_i      (req_i.mouse_dx),
    .mouse_dy_i      (req_i.mouse_dy),
    .mouse_buttons_i (req_i.mouse_buttons),
    .read_data_o     (rsp_o.read_data),
    .handled_o       (rsp_o.handled),
    .kbd_irq_o       (rsp_o.kbd_irq),
    .aux_irq_o       (rsp_o.aux_irq),
    .overflow_o      (rsp_o.overflow)
  );

`ifndef SYNTHESIS
  // After a request is taken, no other request may enter until it finishes.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another was in progress");

  // A finished result must never overwrite one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("output register overwritten before its beat was taken");

  // The queue memory is only read when it holds a byte.
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ram_rd |-> !status.cnt_zero)
    else $error("queue head read while the queue is empty");
`endif

endmodule

`default_nettype wire
